// File: hdl/bhp_pkg.sv
// bhp_pkg: constants and helper functions for the bicubic Hermite patch evaluator.
// No dependencies; imported by bicubic_hermite_patch_eval.
`timescale 1ns / 1ps

package bhp_pkg;

  // request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam int T_W   = 17;   // Q1.16 parameter, 65536 = 1.0
  localparam int CRD_W = 16;   // Q8.8 coordinate
  localparam int OUT_W = 20;   // Q12.8 result
  localparam int H_W   = 32;   // basis / weight, Q.30
  localparam int ACC_W = 52;   // weighted sum, Q.38
  localparam int QW    = 53;   // basis in Q0.48 before rounding

  localparam logic [T_W-1:0] T_ONE = 17'd65536;

  localparam logic signed [QW-1:0] ONE_Q48 = {{(QW-49){1'b0}}, 1'b1, 48'b0};
  localparam logic signed [QW-1:0] HALF_Q18 = {{(QW-18){1'b0}}, 1'b1, 17'b0};

  localparam logic signed [21:0] OUT_MAX = 22'sd524287;
  localparam logic signed [21:0] OUT_MIN = -22'sd524288;

  function automatic logic [T_W-1:0] clamp_t(input logic [T_W-1:0] raw);
    return (raw > T_ONE) ? T_ONE : raw;
  endfunction

  // Hermite basis k at t, from t, t^2, t^3; Q0.48 rounded to Q.30 (half up)
  function automatic logic signed [H_W-1:0] hermite_basis(
    input logic [1:0]  k,
    input logic [16:0] t,
    input logic [32:0] tsq,
    input logic [48:0] tcu
  );
    logic signed [QW-1:0] s1;
    logic signed [QW-1:0] s2;
    logic signed [QW-1:0] s3;
    logic signed [QW-1:0] q;
    logic signed [QW-1:0] r;
    s1 = signed'({{(QW-49){1'b0}}, t, 32'b0});
    s2 = signed'({{(QW-49){1'b0}}, tsq, 16'b0});
    s3 = signed'({{(QW-49){1'b0}}, tcu});
    case (k)
      2'd0: q = ONE_Q48 - ((s2 <<< 1) + s2) + (s3 <<< 1);
      2'd1: q = ((s2 <<< 1) + s2) - (s3 <<< 1);
      2'd2: q = s1 - (s2 <<< 1) + s3;
      default: q = s3 - s2;
    endcase
    r = (q + HALF_Q18) >>> 18;
    return r[H_W-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [21:0] v);
    if (v > OUT_MAX) begin
      return OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      return OUT_MIN[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

// File: hdl/bhp_ram.sv
// bhp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies; holds the geometry matrix of the patch evaluator.
`timescale 1ns / 1ps

module bhp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/bicubic_hermite_patch_eval.sv
// bicubic_hermite_patch_eval: top level, sequencer around one shared multiplier.
// Depends on bhp_pkg and bhp_ram.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | operation, slot, coord_x/y/z, param_first/second
//  out     | out_valid / out_ready| point_x, point_y, point_z
//
// A load request leaves the sequencer idle; ready stays high.
// An evaluate request runs to out_valid (ready returns with it) through t, t^2,
// t^3 and four bases for each parameter, weight and x/y/z products for each of 16
// terms through the single multiplier, a drain step and 3 rounding steps.
// Reset clears the sequencer, the output valid and the per-entry valid bits;
// an entry never loaded reads as zero.
// A stalled result holds in the output registers; requests are still taken,
// but a finishing evaluation waits in rounding until the output is free.
`timescale 1ns / 1ps

module bicubic_hermite_patch_eval (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                operation,
  input  logic [3:0]          slot,
  input  logic signed [15:0]  coord_x,
  input  logic signed [15:0]  coord_y,
  input  logic signed [15:0]  coord_z,
  input  logic [16:0]         param_first,
  input  logic [16:0]         param_second,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [19:0]  point_x,
  output logic signed [19:0]  point_y,
  output logic signed [19:0]  point_z
);

  import bhp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_CUBE,
    ST_BASIS,
    ST_WEIGHT,
    ST_WROUND,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_DRAIN,
    ST_ROUND
  } state_t;

  localparam logic signed [63:0] HALF_W   = 64'sd536870912;
  localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(64'sd536870912);
  localparam logic signed [H_W-1:0] W_ONE  = 32'sd1073741824;

  state_t state;
  logic [T_W-1:0] ta;
  logic [T_W-1:0] tb;
  logic side;
  logic [3:0] cnt;
  logic [32:0] tsq;
  logic signed [63:0] p;
  logic signed [H_W-1:0] h1 [4];
  logic signed [H_W-1:0] h2 [4];
  logic signed [H_W-1:0] w;
  logic signed [ACC_W-1:0] acc [3];
  logic [15:0] gvld;
  logic g_ok;

  logic [T_W-1:0] t_cur;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] mul_y;
  logic signed [H_W-1:0] basis_val;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [OUT_W-1:0] rnd_val;
  logic signed [CRD_W-1:0] gx;
  logic signed [CRD_W-1:0] gy;
  logic signed [CRD_W-1:0] gz;
  logic [47:0] rd_data;
  logic wr_en;
  logic rd_en;

  assign in_ready = (state == ST_IDLE);
  assign wr_en    = in_valid && in_ready && (operation == OP_LOAD);
  assign rd_en    = (state == ST_WEIGHT);

  bhp_ram #(
    .WIDTH(48),
    .DEPTH(16)
  ) u_geom (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data ({coord_z, coord_y, coord_x}),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  // entries never loaded read as zero
  assign gx = g_ok ? signed'(rd_data[15:0])  : '0;
  assign gy = g_ok ? signed'(rd_data[31:16]) : '0;
  assign gz = g_ok ? signed'(rd_data[47:32]) : '0;

  assign t_cur     = side ? tb : ta;
  assign basis_val = hermite_basis(cnt[1:0], t_cur, tsq, p[48:0]);
  assign acc_r     = (acc[cnt[1:0]] + HALF_A) >>> 30;
  assign rnd_val   = sat_out(acc_r[21:0]);

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_SQ: begin
        mul_a = {17'b0, t_cur};
        mul_b = {16'b0, t_cur};
      end
      ST_CUBE: begin
        mul_a = {1'b0, p[32:0]};
        mul_b = {16'b0, t_cur};
      end
      ST_WEIGHT: begin
        mul_a = 34'(h1[cnt[3:2]]);
        mul_b = 33'(h2[cnt[1:0]]);
      end
      ST_MX: begin
        mul_a = 34'(w);
        mul_b = 33'(gx);
      end
      ST_MY: begin
        mul_a = 34'(w);
        mul_b = 33'(gy);
      end
      ST_MZ: begin
        mul_a = 34'(w);
        mul_b = 33'(gz);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_y = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      gvld      <= '0;
      cnt       <= '0;
      side      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (operation == OP_LOAD) begin
              gvld[slot] <= 1'b1;
            end else begin
              ta     <= clamp_t(param_first);
              tb     <= clamp_t(param_second);
              side   <= 1'b0;
              cnt    <= '0;
              acc[0] <= '0;
              acc[1] <= '0;
              acc[2] <= '0;
              state  <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          p     <= mul_y[63:0];
          state <= ST_CUBE;
        end
        ST_CUBE: begin
          tsq   <= p[32:0];
          p     <= mul_y[63:0];
          cnt   <= '0;
          state <= ST_BASIS;
        end
        ST_BASIS: begin
          if (side) begin
            h2[cnt[1:0]] <= basis_val;
          end else begin
            h1[cnt[1:0]] <= basis_val;
          end
          if (cnt[1:0] == 2'd3) begin
            cnt <= '0;
            if (side) begin
              state <= ST_WEIGHT;
            end else begin
              side  <= 1'b1;
              state <= ST_SQ;
            end
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_WEIGHT: begin
          // z product of the previous term is still in p
          if (cnt != 4'd0) begin
            acc[2] <= acc[2] + p[ACC_W-1:0];
          end
          g_ok  <= gvld[cnt];
          p     <= mul_y[63:0];
          state <= ST_WROUND;
        end
        ST_WROUND: begin
          w     <= H_W'((p + HALF_W) >>> 30);
          state <= ST_MX;
        end
        ST_MX: begin
          p     <= mul_y[63:0];
          state <= ST_MY;
        end
        ST_MY: begin
          acc[0] <= acc[0] + p[ACC_W-1:0];
          p      <= mul_y[63:0];
          state  <= ST_MZ;
        end
        ST_MZ: begin
          acc[1] <= acc[1] + p[ACC_W-1:0];
          p      <= mul_y[63:0];
          cnt    <= cnt + 4'd1;
          state  <= (cnt == 4'd15) ? ST_DRAIN : ST_WEIGHT;
        end
        ST_DRAIN: begin
          acc[2] <= acc[2] + p[ACC_W-1:0];
          cnt    <= '0;
          state  <= ST_ROUND;
        end
        ST_ROUND: begin
          // first step waits for a free output register
          if (cnt != 4'd0 || !out_valid || out_ready) begin
            case (cnt[1:0])
              2'd0:    point_x <= rnd_val;
              2'd1:    point_y <= rnd_val;
              default: point_z <= rnd_val;
            endcase
            if (cnt[1:0] == 2'd2) begin
              cnt       <= '0;
              out_valid <= 1'b1;
              state     <= ST_IDLE;
            end else begin
              cnt <= cnt + 4'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_eval_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_EVAL |=> state == ST_SQ && !side)
    else $error("evaluate request did not start the sequencer");

  a_load_marks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_LOAD |=> state == ST_IDLE && gvld[$past(slot)])
    else $error("load request did not mark its entry valid");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_ROUND && $past(cnt) == 4'd2)
    else $error("result raised outside the final rounding step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND && cnt != 4'd0 |-> !out_valid)
    else $error("rounding writes over a pending result");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_MX |-> w <= W_ONE && w >= -W_ONE)
    else $error("weight outside [-1, 1]");

endmodule

// File: tb/bhp_point_checker.sv
// bhp_point_checker: watches both channels of bicubic_hermite_patch_eval, keeps its own
// geometry store, predicts each surface point and compares it with the block's output.
// Depends on bhp_pkg for the opcodes.
`timescale 1ns / 1ps

module bhp_point_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               operation,
  input  logic [3:0]         slot,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  input  logic [16:0]        param_first,
  input  logic [16:0]        param_second,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [19:0] point_x,
  input  logic signed [19:0] point_y,
  input  logic signed [19:0] point_z,
  output int                 fail_count,
  output int                 pending,
  output int                 points_checked
);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
  } point_t;

  localparam longint PT_MAX = 524287;
  localparam longint PT_MIN = -524288;

  vec3_t  geo_store [16];
  point_t due_points [$];
  int     mismatches = 0;
  int     checked = 0;

  // round to nearest, ties toward +inf; >>> on longint is a floor
  function automatic longint round_q(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Hermite basis k at raw parameter t, Q0.48 exact then Q.30
  function automatic longint basis_q30(input int k, input logic [16:0] raw);
    longint t;
    longint tsq;
    longint tcu;
    longint q;
    t = raw;
    if (t > 65536) t = 65536;
    tsq = t * t;
    tcu = tsq * t;
    case (k)
      0:       q = (64'sd1 <<< 48) - 3 * (tsq <<< 16) + 2 * tcu;
      1:       q = 3 * (tsq <<< 16) - 2 * tcu;
      2:       q = (t <<< 32) - 2 * (tsq <<< 16) + tcu;
      default: q = tcu - (tsq <<< 16);
    endcase
    return round_q(q, 18);
  endfunction

  function automatic logic signed [19:0] sat_point(input longint v);
    longint r;
    r = round_q(v, 30);
    if (r > PT_MAX) r = PT_MAX;
    if (r < PT_MIN) r = PT_MIN;
    return r[19:0];
  endfunction

  function automatic point_t surface_point(input logic [16:0] t1, input logic [16:0] t2);
    longint h1 [4];
    longint h2 [4];
    longint w;
    longint ax;
    longint ay;
    longint az;
    point_t p;
    ax = 0;
    ay = 0;
    az = 0;
    for (int k = 0; k < 4; k++) begin
      h1[k] = basis_q30(k, t1);
      h2[k] = basis_q30(k, t2);
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        w = round_q(h1[r] * h2[c], 30);
        ax += w * longint'(geo_store[r * 4 + c].x);
        ay += w * longint'(geo_store[r * 4 + c].y);
        az += w * longint'(geo_store[r * 4 + c].z);
      end
    end
    p.x = sat_point(ax);
    p.y = sat_point(ay);
    p.z = sat_point(az);
    return p;
  endfunction

  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      for (int i = 0; i < 16; i++) geo_store[i] = '0;
      due_points.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      // results first: a point leaving now belongs to an earlier request
      if (out_valid && out_ready) begin
        if (due_points.size() == 0) begin
          $error("point out with none expected: (%0d, %0d, %0d)", point_x, point_y, point_z);
          mismatches++;
        end else begin
          want = due_points.pop_front();
          checked++;
          if (point_x !== want.x) begin
            $error("point_x mismatch: expected %0d, got %0d", want.x, point_x);
            mismatches++;
          end
          if (point_y !== want.y) begin
            $error("point_y mismatch: expected %0d, got %0d", want.y, point_y);
            mismatches++;
          end
          if (point_z !== want.z) begin
            $error("point_z mismatch: expected %0d, got %0d", want.z, point_z);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (operation == bhp_pkg::OP_EVAL) begin
          due_points.insert(due_points.size(), surface_point(param_first, param_second));
        end else begin
          geo_store[slot] = '{coord_x, coord_y, coord_z};
        end
      end
    end
    fail_count     <= mismatches;
    points_checked <= checked;
    pending        <= due_points.size();
  end

endmodule

// File: tb/bicubic_hermite_patch_eval_test.sv
// bicubic_hermite_patch_eval_test: drives load/evaluate requests into the patch
// evaluator under several idle/stall mixes; bhp_point_checker does the checking.
// Depends on bhp_pkg, bicubic_hermite_patch_eval and bhp_point_checker.
`timescale 1ns / 1ps

module bicubic_hermite_patch_eval_test;

  localparam int ITEMS_PER_PHASE = 440;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int TAIL_CYCLES     = 120;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               operation;
  logic [3:0]         slot;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic [16:0]        param_first;
  logic [16:0]        param_second;
  logic               out_valid;
  logic               out_ready;
  logic signed [19:0] point_x;
  logic signed [19:0] point_y;
  logic signed [19:0] point_z;

  int fail_count;
  int pending;
  int points_checked;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_off_reqs   = 0;
  int reqs_sent       = 0;
  int loads_sent      = 0;

  bicubic_hermite_patch_eval i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .slot         (slot),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .param_first  (param_first),
    .param_second (param_second),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z)
  );

  bhp_point_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .slot           (slot),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .coord_z        (coord_z),
    .param_first    (param_first),
    .param_second   (param_second),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_z        (point_z),
    .fail_count     (fail_count),
    .pending        (pending),
    .points_checked (points_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: random stalls, plus a long hold-off each time one is requested
  initial begin
    int served;
    served = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_reqs != served) begin
        served = hold_off_reqs;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #(10_000_000);
    $display("Timeout with %0d points still expected", pending);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_req(input logic op, input logic [3:0] s,
                          input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z,
                          input logic [16:0] t1, input logic [16:0] t2);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    slot         <= s;
    coord_x      <= x;
    coord_y      <= y;
    coord_z      <= z;
    param_first  <= t1;
    param_second <= t2;
    do @(posedge clk); while (!in_ready);
    reqs_sent++;
    if (op == bhp_pkg::OP_LOAD) loads_sent++;
  endtask

  // sender pauses until every expected point has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'($urandom());
    endcase
  endfunction

  // parameters: ends, values above one (clamped), and anywhere in [0, 1]
  function automatic logic [16:0] rand_param();
    case ($urandom_range(7))
      0:       return 17'd0;
      1:       return bhp_pkg::T_ONE;
      2:       return 17'($urandom_range(131071, 65537));
      default: return 17'($urandom_range(65536, 0));
    endcase
  endfunction

  task automatic send_random();
    logic op;
    op = ($urandom_range(99) < 40) ? bhp_pkg::OP_LOAD : bhp_pkg::OP_EVAL;
    send_req(op, 4'($urandom_range(15)), rand_coord(), rand_coord(), rand_coord(),
             rand_param(), rand_param());
  endtask

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    idle_mix  = '{0, 45, 0, 8};
    stall_mix = '{0, 0, 45, 8};
    rst          = 1'b1;
    in_valid     = 1'b0;
    operation    = bhp_pkg::OP_LOAD;
    slot         = '0;
    coord_x      = '0;
    coord_y      = '0;
    coord_z      = '0;
    param_first  = '0;
    param_second = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, corners, tangents, twist, clamping, ignored fields
    send_req(bhp_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0);
    send_req(bhp_pkg::OP_LOAD, 4'd0, 16'sh7fff, 16'sh8000, 16'sd1, 17'd0, 17'd0);
    send_req(bhp_pkg::OP_LOAD, 4'd5, 16'sh8000, 16'sh7fff, -16'sd1, 17'd0, 17'd0);
    send_req(bhp_pkg::OP_LOAD, 4'd4, 16'sd300, -16'sd300, 16'sh7fff, 17'd0, 17'd0);
    send_req(bhp_pkg::OP_LOAD, 4'd1, -16'sd1000, 16'sd999, 16'sd0, 17'd0, 17'd0);
    send_req(bhp_pkg::OP_LOAD, 4'd10, 16'sh1234, -16'sh1234, 16'sh7fff, 17'd0, 17'd0);
    send_req(bhp_pkg::OP_LOAD, 4'd15, -16'sd1, 16'sd0, 16'sh7fff, 17'd0, 17'd0);
    send_req(bhp_pkg::OP_LOAD, 4'd2, 16'sd256, -16'sd256, 16'sd128, 17'd0, 17'd0);
    send_req(bhp_pkg::OP_LOAD, 4'd8, -16'sd512, 16'sd1000, -16'sd3, 17'd0, 17'd0);
    send_req(bhp_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0);
    send_req(bhp_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 17'd65536, 17'd65536);
    send_req(bhp_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 17'd131071, 17'd65537);
    send_req(bhp_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 17'd65536, 17'd0);
    send_req(bhp_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd65536);
    send_req(bhp_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 17'd32768, 17'd32768);
    send_req(bhp_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 17'd1, 17'd65535);
    send_req(bhp_pkg::OP_EVAL, 4'd15, 16'sh7fff, 16'sh8000, 16'shffff, 17'd21845, 17'd43690);
    send_req(bhp_pkg::OP_LOAD, 4'd3, 16'sd77, -16'sd77, 16'sd7, 17'd131071, 17'd98304);
    send_req(bhp_pkg::OP_EVAL, 4'd3, 16'sd0, 16'sd0, 16'sd0, 17'd98304, 17'd16384);
    send_req(bhp_pkg::OP_LOAD, 4'd3, 16'sd0, 16'sd0, 16'sd0, 17'd0, 17'd0);
    send_req(bhp_pkg::OP_EVAL, 4'd0, 16'sd0, 16'sd0, 16'sd0, 17'd49152, 17'd8192);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_mix[ph];
      recv_stall_pct  = stall_mix[ph];
      // first phase: long output hold-off while requests keep coming
      if (ph == 0) hold_off_reqs <= hold_off_reqs + 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random();
      wait_drained();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d loads), checked %0d surface points", reqs_sent,
             loads_sent, points_checked);
    $display("Covered: no idling, sender gaps, output stalls, both, a long hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
